>>> rtl/cwsc_pkg.sv
`timescale 1ns / 1ps
package cwsc_pkg;

  localparam int unsigned MAX_PACKETS = 1024;
  localparam int unsigned MAX_WINDOW  = 32;

  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ADDR_W = $clog2(MAX_PACKETS);
  localparam int unsigned WIN_W  = 6;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned RTT_W  = TICK_W + FRAC_W;
  localparam int unsigned RES_W  = 17;
  localparam int unsigned SIDX_W = 10;

  typedef logic [1:0] status_t;
  localparam status_t ST_UNSENT = 2'd0;
  localparam status_t ST_SENT   = 2'd1;
  localparam status_t ST_ACKED  = 2'd2;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_RTT       = 1'b1;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic ack_chk;
    logic ack_dev;
    logic snd_init;
    logic snd_chk;
    logic tmo_chk;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic ack_more;
    logic ack_hit;
    logic snd_more;
    logic snd_hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // floor(1.0 / window) in Q1.16; window 0 acts as 1
  function automatic logic [RES_W-1:0] recip(input logic [WIN_W-1:0] w);
    logic [RES_W-1:0] r;
    case (w)
      6'd0, 6'd1: r = 17'd65536;
      6'd2:  r = 17'd32768;
      6'd3:  r = 17'd21845;
      6'd4:  r = 17'd16384;
      6'd5:  r = 17'd13107;
      6'd6:  r = 17'd10922;
      6'd7:  r = 17'd9362;
      6'd8:  r = 17'd8192;
      6'd9:  r = 17'd7281;
      6'd10: r = 17'd6553;
      6'd11: r = 17'd5957;
      6'd12: r = 17'd5461;
      6'd13: r = 17'd5041;
      6'd14: r = 17'd4681;
      6'd15: r = 17'd4369;
      6'd16: r = 17'd4096;
      6'd17: r = 17'd3855;
      6'd18: r = 17'd3640;
      6'd19: r = 17'd3449;
      6'd20: r = 17'd3276;
      6'd21: r = 17'd3120;
      6'd22: r = 17'd2978;
      6'd23: r = 17'd2849;
      6'd24: r = 17'd2730;
      6'd25: r = 17'd2621;
      6'd26: r = 17'd2520;
      6'd27: r = 17'd2427;
      6'd28: r = 17'd2340;
      6'd29: r = 17'd2259;
      6'd30: r = 17'd2184;
      6'd31: r = 17'd2114;
      default: r = 17'd2048;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cwsc_if.sv
`timescale 1ns / 1ps
interface cwsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] packet_count;
  logic [10:0] packet_index;
  logic [15:0] now_ticks;
  modport source(output valid, command, packet_count, packet_index, now_ticks, input ready);
  modport sink(input valid, command, packet_count, packet_index, now_ticks, output ready);
endinterface

interface cwsc_rsp_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [9:0] send_index;
  logic [5:0] window_now;
  logic [5:0] threshold_now;
  logic [15:0] timeout_ticks;
  logic       transfer_done;
  logic       is_last;
  modport source(output valid, send_valid, send_index, window_now, threshold_now,
                 timeout_ticks, transfer_done, is_last, input ready);
  modport sink(input valid, send_valid, send_index, window_now, threshold_now,
               timeout_ticks, transfer_done, is_last, output ready);
endinterface

interface cwsc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/congestion_window_sender_control.sv
`timescale 1ns / 1ps
// Sender congestion control: slow start, congestion avoidance and retransmit
// timeout over up to 1024 packets. One command at a time. Reset and every start
// command run a clear pass over all 1024 entries of the packet status memory (one
// entry per cycle) before the next command is taken; start then returns one empty
// result. An ack with next index k walks entries 0..k-1, each newly acknowledged
// packet taking an extra step (RTT then deviation update), then walks the send
// window; the status/stamp memories read one entry per cycle with registered
// output. A timeout waits for the read, checks the entry, then finishes. Results
// leave through a one-deep output register; the walk stalls while it is full.
module congestion_window_sender_control (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwsc_req_if.sink   req_i,
  cwsc_rsp_if.source rsp_o,
  cwsc_cfg_if.sink   cfg_i
);
  import cwsc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  cwsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .sts_i         (sts),
    .ctl_o         (ctl)
  );

  cwsc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .command_i       (req_i.command),
    .packet_count_i  (req_i.packet_count),
    .packet_index_i  (req_i.packet_index),
    .now_ticks_i     (req_i.now_ticks),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .send_valid_o    (rsp_o.send_valid),
    .send_index_o    (rsp_o.send_index),
    .window_now_o    (rsp_o.window_now),
    .threshold_now_o (rsp_o.threshold_now),
    .timeout_ticks_o (rsp_o.timeout_ticks),
    .transfer_done_o (rsp_o.transfer_done),
    .is_last_o       (rsp_o.is_last)
  );
endmodule

>>> rtl/cwsc_ram.sv
`timescale 1ns / 1ps
module cwsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/cwsc_ctrl.sv
`timescale 1ns / 1ps
module cwsc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic [1:0]     req_command_i,
  output logic           req_ready_o,
  input  cwsc_pkg::sts_t sts_i,
  output cwsc_pkg::ctl_t ctl_o
);
  import cwsc_pkg::*;

  typedef enum logic [10:0] {
    S_CLR      = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_ACK_LOOP = 11'b00000000100,
    S_ACK_CHK  = 11'b00000001000,
    S_ACK_DEV  = 11'b00000010000,
    S_SND_INIT = 11'b00000100000,
    S_SND_LOOP = 11'b00001000000,
    S_SND_CHK  = 11'b00010000000,
    S_TMO_WAIT = 11'b00100000000,
    S_TMO_CHK  = 11'b01000000000,
    S_FIN      = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    ctl_o   = '0;
    case (state_q)
      S_CLR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = emit_q ? S_FIN : S_IDLE;
          emit_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          ctl_o.accept = 1'b1;
          case (req_command_i)
            CMD_START: begin
              state_d = S_CLR;
              emit_d  = 1'b1;
            end
            CMD_ACK:     state_d = S_ACK_LOOP;
            CMD_TIMEOUT: state_d = S_TMO_WAIT;
            default:     state_d = S_FIN;
          endcase
        end
      end
      S_ACK_LOOP: state_d = sts_i.ack_more ? S_ACK_CHK : S_SND_INIT;
      S_ACK_CHK: begin
        ctl_o.ack_chk = 1'b1;
        state_d = sts_i.ack_hit ? S_ACK_DEV : S_ACK_LOOP;
      end
      S_ACK_DEV: begin
        ctl_o.ack_dev = 1'b1;
        state_d = S_ACK_LOOP;
      end
      S_SND_INIT: begin
        ctl_o.snd_init = 1'b1;
        state_d = S_SND_LOOP;
      end
      S_SND_LOOP: state_d = sts_i.snd_more ? S_SND_CHK : S_FIN;
      S_SND_CHK: begin
        if (!(sts_i.snd_hit && sts_i.pend_valid && !sts_i.out_free)) begin
          ctl_o.snd_chk = 1'b1;
          state_d = S_SND_LOOP;
        end
      end
      S_TMO_WAIT: state_d = S_TMO_CHK;
      S_TMO_CHK: begin
        ctl_o.tmo_chk = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  a_wait_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SND_CHK && sts_i.snd_hit && sts_i.pend_valid && !sts_i.out_free)
    |=> state_q == S_SND_CHK)
    else $error("send check left while output blocked");
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.pend_valid)
    else $error("pending result left at idle");
  a_clr_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && !sts_i.clr_last) |=> state_q == S_CLR)
    else $error("clear pass cut short");
endmodule

>>> rtl/cwsc_dp.sv
`timescale 1ns / 1ps
module cwsc_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cwsc_pkg::ctl_t ctl_i,
  output cwsc_pkg::sts_t sts_o,
  input  logic [1:0]     command_i,
  input  logic [10:0]    packet_count_i,
  input  logic [10:0]    packet_index_i,
  input  logic [15:0]    now_ticks_i,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  output logic           send_valid_o,
  output logic [9:0]     send_index_o,
  output logic [5:0]     window_now_o,
  output logic [5:0]     threshold_now_o,
  output logic [15:0]    timeout_ticks_o,
  output logic           transfer_done_o,
  output logic           is_last_o
);
  import cwsc_pkg::*;

  logic [WIN_W-1:0]  thr_cfg_q;
  logic [TICK_W-1:0] rtt_cfg_q;
  logic [WIN_W-1:0]  win_q, thr_q;
  logic [RES_W-1:0]  res_q;
  logic [RTT_W-1:0]  rtt_q, dev_q, s_q;
  logic [IDX_W-1:0]  total_q, acked_q, k_q, i_q, end_q, idx_q;
  logic [TICK_W-1:0] now_q;
  logic [SIDX_W-1:0] pend_q;
  logic              pend_v_q;

  logic              out_v_q, out_sv_q, out_done_q, out_last_q;
  logic [SIDX_W-1:0] out_idx_q;
  logic [WIN_W-1:0]  out_win_q, out_thr_q;
  logic [TICK_W-1:0] out_tmo_q;

  status_t           st_rd, st_wdata;
  logic              st_we, sp_we;
  logic [TICK_W-1:0] stamp_rd;

  logic [IDX_W-1:0]  cnt_sat, k_sat, end_v;
  logic [WIN_W-1:0]  thr_init, win_grow;
  logic [RTT_W-1:0]  sample, rtt_new, diff, dev_new;
  logic [RTT_W+2:0]  rtt_sum;
  logic [RTT_W+1:0]  dev_sum;
  logic [RES_W-1:0]  res_sum, res_grow;
  logic [WIN_W:0]    win_inc;
  logic [IDX_W:0]    end_sum;
  logic [RTT_W+2:0]  tmo_sum;
  logic [TICK_W-1:0] tmo_val;
  logic              ack_hit, snd_hit, tmo_hit, out_free, push, push_sv;
  logic [SIDX_W-1:0] push_idx;

  cwsc_ram #(.Width(2), .Depth(MAX_PACKETS)) u_status (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (i_q[ADDR_W-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (i_q[ADDR_W-1:0]),
    .rdata_o (st_rd)
  );

  cwsc_ram #(.Width(TICK_W), .Depth(MAX_PACKETS)) u_stamp (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (i_q[ADDR_W-1:0]),
    .wdata_i (now_q),
    .raddr_i (i_q[ADDR_W-1:0]),
    .rdata_o (stamp_rd)
  );

  always_comb begin
    cnt_sat  = (packet_count_i > IDX_W'(MAX_PACKETS)) ? IDX_W'(MAX_PACKETS) : packet_count_i;
    k_sat    = (packet_index_i > total_q) ? total_q : packet_index_i;
    thr_init = (thr_cfg_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : thr_cfg_q;

    sample  = {now_q - stamp_rd, {FRAC_W{1'b0}}};
    rtt_sum = {rtt_q, 3'b000} - {3'b000, rtt_q} + {3'b000, sample};
    rtt_new = rtt_sum[RTT_W+2:3];

    diff    = (s_q > rtt_q) ? s_q - rtt_q : rtt_q - s_q;
    dev_sum = {2'b00, dev_q} + {1'b0, dev_q, 1'b0} + {2'b00, diff};
    dev_new = dev_sum[RTT_W+1:2];

    res_sum = res_q + recip(win_q);
    if (win_q < thr_q) begin
      win_inc  = {1'b0, win_q} + 7'd1;
      res_grow = res_q;
    end else begin
      win_inc  = {1'b0, win_q} + {6'd0, res_sum[RES_W-1]};
      res_grow = {1'b0, res_sum[RES_W-2:0]};
    end
    win_grow = (win_inc > 7'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_inc[WIN_W-1:0];

    end_sum = {1'b0, k_q} + {6'd0, win_q};
    end_v   = (end_sum > {1'b0, total_q}) ? total_q : end_sum[IDX_W-1:0];

    tmo_sum = {3'b000, rtt_q} + {1'b0, dev_q, 2'b00};
    tmo_val = (|tmo_sum[RTT_W+2:RTT_W]) ? {TICK_W{1'b1}} : tmo_sum[RTT_W-1:FRAC_W];

    ack_hit = (st_rd != ST_ACKED);
    snd_hit = (st_rd == ST_UNSENT) || (i_q == k_q);
    tmo_hit = (idx_q < total_q) && (st_rd == ST_SENT);
    out_free = !out_v_q || rsp_ready_i;

    st_we    = ctl_i.clr_step || (ctl_i.ack_chk && ack_hit) || (ctl_i.snd_chk && snd_hit);
    st_wdata = ctl_i.clr_step ? ST_UNSENT : (ctl_i.ack_chk ? ST_ACKED : ST_SENT);
    sp_we    = (ctl_i.snd_chk && snd_hit) || (ctl_i.tmo_chk && tmo_hit);

    push     = (ctl_i.snd_chk && snd_hit && pend_v_q) || ctl_i.fin;
    push_sv  = pend_v_q;
    push_idx = pend_v_q ? pend_q : '0;
  end

  assign sts_o.clr_last   = (i_q == IDX_W'(MAX_PACKETS - 1));
  assign sts_o.ack_more   = (i_q < k_q);
  assign sts_o.ack_hit    = ack_hit;
  assign sts_o.snd_more   = (i_q < end_q);
  assign sts_o.snd_hit    = snd_hit;
  assign sts_o.pend_valid = pend_v_q;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_cfg_q <= WIN_W'(32);
      rtt_cfg_q <= TICK_W'(3);
      win_q     <= WIN_W'(1);
      thr_q     <= WIN_W'(32);
      res_q     <= '0;
      rtt_q     <= RTT_W'(768);
      dev_q     <= '0;
      total_q   <= '0;
      acked_q   <= '0;
      k_q       <= '0;
      i_q       <= '0;
      end_q     <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_THRESHOLD) begin
          thr_cfg_q <= cfg_data_i[WIN_W-1:0];
        end else begin
          rtt_cfg_q <= cfg_data_i;
        end
      end
      if (ctl_i.accept) begin
        case (command_i)
          CMD_START: begin
            total_q <= cnt_sat;
            thr_q   <= thr_init;
            win_q   <= WIN_W'(1);
            res_q   <= '0;
            rtt_q   <= {rtt_cfg_q, {FRAC_W{1'b0}}};
            dev_q   <= '0;
            acked_q <= '0;
            i_q     <= '0;
          end
          CMD_ACK: begin
            k_q <= k_sat;
            i_q <= '0;
          end
          CMD_TIMEOUT: i_q <= packet_index_i;
          default: ;
        endcase
      end
      if (ctl_i.clr_step) begin
        i_q <= i_q + 1'b1;
      end
      if (ctl_i.ack_chk) begin
        if (ack_hit) begin
          rtt_q <= rtt_new;
          s_q   <= sample;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      if (ctl_i.ack_dev) begin
        dev_q <= dev_new;
        win_q <= win_grow;
        res_q <= res_grow;
        i_q   <= i_q + 1'b1;
      end
      if (ctl_i.snd_init) begin
        acked_q <= k_q;
        i_q     <= k_q;
        end_q   <= end_v;
      end
      if (ctl_i.snd_chk) begin
        i_q <= i_q + 1'b1;
        if (snd_hit) begin
          pend_q   <= i_q[SIDX_W-1:0];
          pend_v_q <= 1'b1;
        end
      end
      if (ctl_i.tmo_chk && tmo_hit) begin
        thr_q    <= win_q >> 1;
        win_q    <= WIN_W'(1);
        pend_q   <= i_q[SIDX_W-1:0];
        pend_v_q <= 1'b1;
      end
      if (ctl_i.fin) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      idx_q <= packet_index_i;
      now_q <= now_ticks_i;
    end
    if (push) begin
      out_sv_q   <= push_sv;
      out_idx_q  <= push_idx;
      out_win_q  <= win_q;
      out_thr_q  <= thr_q;
      out_tmo_q  <= tmo_val;
      out_done_q <= (acked_q == total_q);
      out_last_q <= ctl_i.fin;
    end
  end

  assign rsp_valid_o     = out_v_q;
  assign send_valid_o    = out_sv_q;
  assign send_index_o    = out_idx_q;
  assign window_now_o    = out_win_q;
  assign threshold_now_o = out_thr_q;
  assign timeout_ticks_o = out_tmo_q;
  assign transfer_done_o = out_done_q;
  assign is_last_o       = out_last_q;

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q != '0) && (win_q <= WIN_W'(MAX_WINDOW)))
    else $error("window out of range");
  a_res_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_q[RES_W-1])
    else $error("residue kept a whole unit");
  a_acked_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acked_q <= total_q)
    else $error("acked index beyond packet count");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result overwritten before transaction");
endmodule
